// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds on every clock edge outside of reset.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int NUM_WIDTH = 32;
  localparam int WW = 64;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_CMP = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_MOD_NI  = 3'd2;
  localparam logic [2:0] ST_MOD_Z   = 3'd3;
  localparam logic [2:0] ST_OVF     = 3'd4;

  // Request and result of the shared divide and gcd unit.
  typedef struct packed {
    logic          start;
    logic          is_gcd;
    logic [WW-1:0] x;
    logic [WW-1:0] y;
  } dg_req_t;

  typedef struct packed {
    logic          done;
    logic [WW-1:0] q;
    logic [WW-1:0] r;
  } dg_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rau_divgcd.sv =====
// ----------------------------------------------------------------------------
// rau_divgcd
// Iterative unit: restoring division one bit a cycle, or binary gcd one
// step a cycle, on 64-bit unsigned values.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_divgcd
  import rau_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire dg_req_t req,
  output dg_rsp_t      rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_GCD  = 4'b0100,
    S_DONE = 4'b1000
  } dg_state_t;

  dg_state_t state_r, state_nxt;
  logic [WW-1:0] x_r, x_nxt, y_r, y_nxt, q_r, q_nxt, rm_r, rm_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [WW:0] trial;

  // Sequencer and datapath; gcd keeps the shared power of two in cnt_r.
  // A new request is also taken in the cycle that presents the last result.
  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; y_nxt = y_r; q_nxt = q_r; rm_nxt = rm_r; cnt_nxt = cnt_r;
    trial = {rm_r, q_r[WW-1]} - {1'b0, y_r};
    case (state_r)
      S_IDLE, S_DONE: begin
        state_nxt = S_IDLE;
        if (req.start) begin
          x_nxt = req.x; y_nxt = req.y; rm_nxt = '0; cnt_nxt = '0;
          q_nxt = req.x;
          state_nxt = req.is_gcd ? S_GCD : S_DIV;
          if (req.is_gcd && (req.x == '0 || req.y == '0)) begin
            q_nxt = req.x | req.y;
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (!trial[WW]) begin
          rm_nxt = trial[WW-1:0];
          q_nxt = {q_r[WW-2:0], 1'b1};
        end else begin
          rm_nxt = {rm_r[WW-2:0], q_r[WW-1]};
          q_nxt = {q_r[WW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(WW - 1)) state_nxt = S_DONE;
      end
      S_GCD: begin
        if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1; y_nxt = y_r >> 1; cnt_nxt = cnt_r + 7'd1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r == y_r) begin
          q_nxt = x_r << cnt_r[5:0];
          state_nxt = S_DONE;
        end else if (x_r > y_r) begin
          x_nxt = x_r - y_r;
        end else begin
          y_nxt = y_r - x_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; q_r <= q_nxt; rm_r <= rm_nxt; cnt_r <= cnt_nxt;
  end

  assign rsp.done = (state_r == S_DONE);
  assign rsp.q    = q_r;
  assign rsp.r    = rm_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact fraction arithmetic with full gcd reduction and status flags.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one operation: opcode and two fractions.
//   The out_ channel returns one result per operation: reduced fraction,
//   three-way compare outcome and status code.
//   One operation is taken at a time; in_tready is low while it works.
//   Sequence: each product uses the shared 33x33 multiplier; two products,
//   then a sum step that also forms the denominator product, then a check
//   step. Reduction runs the shared gcd unit and then two restoring
//   divisions on the same unit. Modulus runs one division on that unit;
//   compare and error cases do not use it.
//   The result sits in an output register until out_tready; in_tready stays
//   low until that result has been transferred, so a stalled receiver also
//   stalls the input.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   out_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rational_arithmetic_unit_top
  import rau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // opcode[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98]
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // res_num[31:0], res_den[62:32], cmp_result[64:63], status[67:65]
  output logic [71:0]       out_tdata
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL1  = 10'b0000000010,
    S_MUL2  = 10'b0000000100,
    S_SUM   = 10'b0000001000,
    S_PREP  = 10'b0000010000,
    S_GCD   = 10'b0000100000,
    S_DIVN  = 10'b0001000000,
    S_DIVD  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_MODD  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]  op_r;
  logic signed [31:0] an_r, bn_r;
  logic [30:0] ad_r, bd_r;
  logic signed [WW-1:0] p0_r, p1_r;
  logic        neg_r;
  logic [WW-1:0] mag_r, den_r, g_r;
  logic        ovld_r;
  logic [71:0] odata_r;

  // Operand select for the one shared signed multiplier.
  logic signed [32:0] mx, my;
  logic signed [65:0] prod;
  always_comb begin
    mx = 33'(an_r); my = 33'(signed'({1'b0, bd_r}));
    case (state_r)
      S_MUL1: begin
        if (op_r == OP_MUL) begin
          mx = 33'(an_r); my = 33'(bn_r);
        end else if (op_r == OP_DIV || op_r == OP_CMP) begin
          mx = 33'(an_r); my = signed'({2'b0, bd_r});
        end else begin
          mx = 33'(an_r); my = signed'({2'b0, bd_r});
        end
      end
      S_MUL2: begin
        if (op_r == OP_MUL) begin
          mx = signed'({2'b0, ad_r}); my = signed'({2'b0, bd_r});
        end else begin
          mx = 33'(bn_r); my = signed'({2'b0, ad_r});
        end
      end
      // Denominator product for add and subtract.
      S_SUM: begin
        mx = signed'({2'b0, ad_r}); my = signed'({2'b0, bd_r});
      end
      default: ;
    endcase
    prod = mx * my;
  end

  // Helpers on registered values.
  logic signed [WW-1:0] sum;
  assign sum = (op_r == OP_SUB) ? p0_r - p1_r : p0_r + p1_r;

  dg_req_t dreq;
  dg_rsp_t drsp;
  rau_divgcd u_dg (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Final packing of an arithmetic result.
  logic [WW-1:0] lim;
  logic ovf;
  logic negf;
  logic [31:0] rn;
  assign lim = WW'(1) << (NUM_WIDTH - 1);
  always_comb begin
    negf = neg_r && (mag_r != '0);
    ovf = negf ? (mag_r > lim) : (mag_r >= lim);
    if (den_r >= lim) ovf = 1'b1;
    rn = negf ? 32'(-mag_r) : mag_r[31:0];
  end

  logic take;
  assign in_tready = (state_r == S_IDLE) && !ovld_r;
  assign take = in_tvalid && in_tready;

  logic signed [1:0] cmp_v;
  always_comb begin
    if ((ad_r == 31'd1 && bd_r == 31'd1) || (ad_r == '0 && bd_r == '0))
      cmp_v = (an_r > bn_r) ? 2'sd1 : ((an_r < bn_r) ? -2'sd1 : 2'sd0);
    else if (ad_r == '0)
      cmp_v = (an_r > 0) ? 2'sd1 : -2'sd1;
    else if (bd_r == '0)
      cmp_v = (bn_r > 0) ? -2'sd1 : 2'sd1;
    else
      cmp_v = (p0_r > p1_r) ? 2'sd1 : ((p0_r < p1_r) ? -2'sd1 : 2'sd0);
  end

  // Simple-compare test on the raw input fields.
  function automatic logic cmp_simple_in();
    logic [30:0] a, b;
    a = in_tdata[65:35]; b = in_tdata[128:98];
    return (a == 31'd1 && b == 31'd1) || a == '0 || b == '0;
  endfunction

  // Sequencer.
  logic [71:0] odata_nxt;
  logic ovld_nxt;
  always_comb begin
    state_nxt = state_r;
    dreq = '0;
    odata_nxt = odata_r;
    ovld_nxt = ovld_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_tdata[2:0])
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_nxt = S_MUL1;
            OP_CMP: state_nxt = cmp_simple_in() ? S_FIN : S_MUL1;
            OP_MOD: state_nxt = S_MODD;
            default: begin
              odata_nxt = '0; ovld_nxt = 1'b1;
            end
          endcase
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = (op_r == OP_CMP) ? S_FIN : S_SUM;
      S_SUM:  state_nxt = S_PREP;
      S_MODD: begin
        if (ad_r != 31'd1 || bd_r != 31'd1) begin
          odata_nxt = {4'b0, ST_MOD_NI, 65'b0}; ovld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (bn_r == 0) begin
          odata_nxt = {4'b0, ST_MOD_Z, 65'b0}; ovld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          dreq.start = 1'b1; dreq.is_gcd = 1'b0;
          dreq.x = WW'(an_r[31] ? 33'(-33'(an_r)) : 33'(an_r));
          dreq.y = WW'(bn_r[31] ? 33'(-33'(bn_r)) : 33'(bn_r));
          state_nxt = S_DIVD;
        end
      end
      S_PREP: begin
        if (mag_r == '0 && den_r == '0) begin
          odata_nxt = {4'b0, ST_ZERO, 65'b0}; ovld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          dreq.start = 1'b1; dreq.is_gcd = 1'b1;
          dreq.x = mag_r; dreq.y = den_r;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (drsp.done) begin
          dreq.start = 1'b1; dreq.x = mag_r; dreq.y = drsp.q;
          state_nxt = S_DIVN;
        end
      end
      S_DIVN: begin
        if (drsp.done) begin
          dreq.start = 1'b1; dreq.x = den_r; dreq.y = g_r;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (drsp.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (op_r == OP_CMP)
          odata_nxt = {4'b0, ST_OK, cmp_v, 63'b0};
        else
          odata_nxt = {4'b0, ovf ? ST_OVF : ST_OK, 2'b0, den_r[30:0], rn};
        ovld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    odata_r <= odata_nxt;
    if (take) begin
      op_r <= in_tdata[2:0];
      an_r <= in_tdata[34:3];  ad_r <= in_tdata[65:35];
      bn_r <= in_tdata[97:66]; bd_r <= in_tdata[128:98];
    end
    case (state_r)
      S_MUL1: p0_r <= WW'(prod);
      S_MUL2: p1_r <= WW'(prod);
      S_SUM: begin
        if (op_r == OP_MUL) begin
          neg_r <= p0_r[WW-1]; mag_r <= p0_r[WW-1] ? WW'(-p0_r) : WW'(p0_r);
          den_r <= p1_r;
        end else if (op_r == OP_DIV) begin
          neg_r <= p0_r[WW-1] != p1_r[WW-1];
          mag_r <= p0_r[WW-1] ? WW'(-p0_r) : WW'(p0_r);
          den_r <= p1_r[WW-1] ? WW'(-p1_r) : WW'(p1_r);
        end else begin
          neg_r <= sum[WW-1]; mag_r <= sum[WW-1] ? WW'(-sum) : WW'(sum);
          den_r <= WW'(prod);
        end
      end
      S_MODD: begin
        neg_r <= an_r[31]; den_r <= WW'(1);
      end
      S_GCD: if (drsp.done) g_r <= drsp.q;
      S_DIVN: if (drsp.done) mag_r <= drsp.q;
      S_DIVD: begin
        if (drsp.done) begin
          if (op_r == OP_MOD) mag_r <= drsp.r;
          else den_r <= drsp.q;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  // Shorthand terms for the checks below.
  logic take_long, out_wait;
  assign take_long = take && in_tdata[2:0] <= OP_MOD;
  assign out_wait  = out_tvalid && !out_tready;

  `ASSERT_CLK(a_busy_not_ready, clk, rst_n, !(state_r != S_IDLE && in_tready), "ready while busy")
  `ASSERT_NEXT(a_take_leaves, clk, rst_n, take_long, state_r != S_IDLE, "item not started")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_wait, out_tvalid && $stable(out_tdata), "result dropped")

endmodule

`default_nettype wire

// ===== dv/tb_rational_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit_top
// Self-checking bench for the rational arithmetic unit. A queue of operations
// feeds a clocked driver; a clocked monitor compares every result transfer
// with the fraction arithmetic worked out here, under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rational_arithmetic_unit_top;
  import rau_pkg::*;

  // Packed from the top bit down, so num sits in the lowest bits.
  typedef struct packed {
    logic [2:0]         st;
    logic signed [1:0]  cmp;
    logic [30:0]        den;
    logic signed [31:0] num;
  } frac_res_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] an;
    logic [30:0]        ad;
    logic signed [31:0] bn;
    logic [30:0]        bd;
  } frac_op_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] OP_RSV6 = 3'd6;
  localparam logic [2:0] OP_RSV7 = 3'd7;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;

  frac_op_t  op_queue[$];
  frac_res_t expected_results[$];
  int        errors = 0;
  int        send_idle_pct = 28;
  int        recv_idle_pct = 46;
  int        hold_cycles = 0;
  bit        sender_pause = 1'b0;
  int        quiet_cycles = 0;

  rational_arithmetic_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [63:0] abs_s64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Reduces a sign/magnitude fraction and flags results that do not fit.
  function automatic frac_res_t reduce_frac(bit neg, logic [63:0] mag, logic [63:0] den);
    frac_res_t r;
    logic [63:0] g;
    logic [63:0] lim;
    logic [63:0] sn;
    bit ovf;
    r = '0;
    if (mag == 0 && den == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    g = (mag == 0) ? den : (den == 0) ? mag : gcd_u64(mag, den);
    mag = mag / g;
    den = den / g;
    if (mag == 0) neg = 1'b0;
    lim = 64'd1 << (NUM_WIDTH - 1);
    ovf = neg ? (mag > lim) : (mag >= lim);
    if (den >= lim) ovf = 1'b1;
    sn = neg ? -mag : mag;
    r.num = sn[31:0];
    r.den = den[30:0];
    r.st = ovf ? ST_OVF : ST_OK;
    return r;
  endfunction

  function automatic frac_res_t predict_frac(frac_op_t o);
    frac_res_t r;
    logic signed [63:0] an, ad, bn, bd, n, d, x, y;
    an = o.an; bn = o.bn;
    ad = {33'd0, o.ad}; bd = {33'd0, o.bd};
    r = '0;
    case (o.op)
      OP_ADD, OP_SUB: begin
        if (o.op == OP_SUB) bn = -bn;
        n = an * bd + bn * ad;
        d = ad * bd;
        r = reduce_frac(n < 0, abs_s64(n), d);
      end
      OP_MUL: begin
        n = an * bn;
        d = ad * bd;
        r = reduce_frac(n < 0, abs_s64(n), d);
      end
      OP_DIV: begin
        n = an * bd;
        d = ad * bn;
        r = reduce_frac((n < 0) != (d < 0), abs_s64(n), abs_s64(d));
      end
      OP_MOD: begin
        if (ad != 1 || bd != 1) r.st = ST_MOD_NI;
        else if (bn == 0) r.st = ST_MOD_Z;
        else r = reduce_frac(an < 0, abs_s64(an) % abs_s64(bn), 64'd1);
      end
      OP_CMP: begin
        if ((ad == 1 && bd == 1) || (ad == 0 && bd == 0)) begin
          x = an; y = bn;
        end else if (ad == 0) begin
          x = (an > 0) ? 1 : -1; y = 0;
        end else if (bd == 0) begin
          x = (bn > 0) ? -1 : 1; y = 0;
        end else begin
          x = an * bd; y = bn * ad;
        end
        r.cmp = (x > y) ? 2'sd1 : (x < y) ? -2'sd1 : 2'sd0;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic queue_op(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
                          logic [31:0] bn, logic [30:0] bd);
    frac_op_t o;
    o.op = op; o.an = an; o.ad = ad; o.bn = bn; o.bd = bd;
    op_queue.push_back(o);
  endtask

  // Mostly small denominators, some zero, one or full-range.
  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1, 2: return 31'd1;
      3: return 31'($urandom);
      default: return 31'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  task automatic queue_random(int count);
    logic [2:0] op;
    repeat (count) begin
      op = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      queue_op(op, rand_num(), rand_den(), rand_num(), rand_den());
    end
  endtask

  task automatic wait_drained();
    while (op_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Driver: offers queued operations and predicts each one on its transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_results.push_back(predict_frac(op_queue.pop_front()));
      if (!(in_tvalid && !in_tready)) begin
        if ((in_tvalid && in_tready ? op_queue.size() > 0 : op_queue.size() > 0 && !in_tvalid)
            && !sender_pause && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, op_queue[0].bd, op_queue[0].bn, op_queue[0].ad,
                       op_queue[0].an, op_queue[0].op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    frac_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[67:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer %h", got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.num !== want.num) begin
            $error("res_num expected %0d actual %0d", want.num, got.num); errors++;
          end
          if (got.den !== want.den) begin
            $error("res_den expected %0d actual %0d", want.den, got.den); errors++;
          end
          if (got.cmp !== want.cmp) begin
            $error("cmp_result expected %0d actual %0d", want.cmp, got.cmp); errors++;
          end
          if (got.st !== want.st) begin
            $error("status expected %0d actual %0d", want.st, got.st); errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation and the special cases.
    queue_op(OP_ADD, 32'h7fffffff, 31'h7fffffff, 32'h80000000, 31'h7fffffff);
    queue_op(OP_ADD, 32'h7fffffff, 31'd1, 32'd1, 31'd1);
    queue_op(OP_SUB, 32'd1, 31'd0, 32'd1, 31'd0);
    queue_op(OP_SUB, 32'h80000000, 31'd1, 32'd1, 31'd1);
    queue_op(OP_MUL, 32'd0, 31'd1, 32'd5, 31'd0);
    queue_op(OP_MUL, 32'h80000000, 31'd1, 32'h80000000, 31'd1);
    queue_op(OP_MUL, 32'd6, 31'd4, -32'sd10, 31'd9);
    queue_op(OP_DIV, 32'd3, 31'd4, -32'sd3, 31'd8);
    queue_op(OP_DIV, 32'd1, 31'd2, 32'd0, 31'd3);
    queue_op(OP_DIV, 32'd0, 31'd2, 32'd0, 31'd3);
    queue_op(OP_DIV, 32'd1, 31'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    queue_op(OP_MOD, -32'sd7, 31'd1, 32'd3, 31'd1);
    queue_op(OP_MOD, 32'h80000000, 31'd1, -32'sd1, 31'd1);
    queue_op(OP_MOD, 32'd7, 31'd2, 32'd3, 31'd1);
    queue_op(OP_MOD, 32'd7, 31'd1, 32'd0, 31'd1);
    queue_op(OP_CMP, 32'd5, 31'd1, 32'd3, 31'd1);
    queue_op(OP_CMP, -32'sd1, 31'd0, 32'd1, 31'd0);
    queue_op(OP_CMP, 32'd0, 31'd0, 32'd1, 31'd3);
    queue_op(OP_CMP, 32'd1, 31'd3, 32'd2, 31'd0);
    queue_op(OP_CMP, 32'd1, 31'd3, 32'd2, 31'd6);
    queue_op(OP_RSV6, 32'hffffffff, 31'h7fffffff, 32'hffffffff, 31'h7fffffff);
    queue_op(OP_RSV7, 32'd1, 31'd1, 32'd1, 31'd1);
    queue_random(280);
    wait_drained();

    // Long receiver hold-off so the block stalls its input.
    send_idle_pct = 46; recv_idle_pct = 28;
    queue_random(10);
    hold_cycles = 2000;
    queue_random(270);
    wait_drained();

    // Sender pauses with operations queued, then resumes.
    sender_pause = 1'b1;
    queue_random(20);
    repeat (50) @(posedge clk);
    sender_pause = 1'b0;
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    queue_random(270);
    wait_drained();

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_divgcd.sv
hw/rtl/rational_arithmetic_unit_top.sv
dv/tb_rational_arithmetic_unit_top.sv
